### hdl/hid_macro_key_sequencer_assert.svh
// assertion macros shared by the key sequencer modules
`ifndef HID_MACRO_KEY_SEQUENCER_ASSERT_SVH
`define HID_MACRO_KEY_SEQUENCER_ASSERT_SVH
`ifndef ASSERT_OFF
`define HMKS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define HMKS_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define HMKS_ASSERT(name, clk, rst, prop, msg)
`define HMKS_NEVER(name, clk, rst, expr, msg)
`endif
`endif

### hdl/hmks_pkg.sv
// types, codes and the macro table of the key sequencer
package hmks_pkg;

   localparam int SEQ_LEN = 10;
   localparam int SEQ_CNT_W = 5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // item types on the request channel
   localparam logic [1:0] REQ_TICK    = 2'd0;
   localparam logic [1:0] REQ_POLL    = 2'd1;
   localparam logic [1:0] REQ_CONTROL = 2'd2;

   // result kinds
   localparam logic [1:0] RESP_REPORT  = 2'd0;
   localparam logic [1:0] RESP_EMPTY   = 2'd1;
   localparam logic [1:0] RESP_CONTROL = 2'd2;

   // control request codes: request type low byte, request high byte
   localparam logic [15:0] CODE_GET_REPORT   = 16'h01A1;
   localparam logic [15:0] CODE_GET_IDLE     = 16'h02A1;
   localparam logic [15:0] CODE_GET_PROTOCOL = 16'h03A1;
   localparam logic [15:0] CODE_SET_IDLE     = 16'h0A21;
   localparam logic [15:0] CODE_SET_PROTOCOL = 16'h0B21;

   localparam logic [3:0] BOOT_REPORT_LEN = 4'd8;

   // configuration register indexes
   localparam logic [1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [1:0] CSR_ENDPOINT = 2'd1;
   localparam logic [1:0] CSR_PRESSED  = 2'd2;

   localparam logic [7:0] DEBOUNCE_RESET = 8'd20;
   localparam logic [3:0] ENDPOINT_RESET = 4'd1;
   localparam logic       PRESSED_RESET  = 1'b0;

   typedef enum logic [3:0] {
      OP_TICK,
      OP_POLL_KBD,
      OP_POLL_OTHER,
      OP_GET_REPORT,
      OP_GET_IDLE,
      OP_GET_PROTOCOL,
      OP_SET_IDLE,
      OP_SET_PROTOCOL,
      OP_ACK
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       level;
      logic [7:0] arg;
      logic [3:0] len;
   } cmd_type;

   function automatic logic [7:0] seq_modifier(input logic [3:0] row);
      logic [7:0] m;
      case (row)
         4'd0, 4'd4, 4'd8: m = 8'h02;
         default:          m = 8'h00;
      endcase
      return m;
   endfunction

   function automatic logic [7:0] seq_key(input logic [3:0] row);
      logic [7:0] k;
      case (row)
         4'd0:    k = 8'h04;
         4'd2:    k = 8'h05;
         4'd4:    k = 8'h06;
         4'd6:    k = 8'h07;
         4'd8:    k = 8'h08;
         default: k = 8'h00;
      endcase
      return k;
   endfunction

endpackage

### hdl/hmks_front.sv
// front end: takes request beats and turns them into queue commands
module hmks_front
   import hmks_pkg::*;
(
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic        req_key_level,
   input  logic [3:0]  req_endpoint,
   input  logic [15:0] req_request_code,
   input  logic [15:0] req_request_value,
   input  logic [15:0] req_request_length,
   input  logic [3:0]  kbd_endpoint,
   input  logic        q_full,
   output logic        q_push,
   output cmd_type     q_cmd
);

   logic [3:0] len_report;
   logic [3:0] len_byte;

   assign req_ready  = !q_full;
   assign len_report = (|req_request_length[15:3]) ? BOOT_REPORT_LEN
                                                    : req_request_length[3:0];
   assign len_byte   = {3'b000, |req_request_length};

   always_comb begin
      q_push      = 1'b0;
      q_cmd.op    = OP_ACK;
      q_cmd.level = req_key_level;
      q_cmd.arg   = 8'h00;
      q_cmd.len   = 4'd0;
      case (req_type)
         REQ_TICK: begin
            q_push   = req_valid && !q_full;
            q_cmd.op = OP_TICK;
         end
         REQ_POLL: begin
            q_push   = req_valid && !q_full;
            q_cmd.op = (req_endpoint == kbd_endpoint) ? OP_POLL_KBD : OP_POLL_OTHER;
         end
         REQ_CONTROL: begin
            q_push = req_valid && !q_full;
            case (req_request_code)
               CODE_GET_REPORT: begin
                  q_cmd.op  = OP_GET_REPORT;
                  q_cmd.len = len_report;
               end
               CODE_GET_IDLE: begin
                  q_cmd.op  = OP_GET_IDLE;
                  q_cmd.len = len_byte;
               end
               CODE_GET_PROTOCOL: begin
                  q_cmd.op  = OP_GET_PROTOCOL;
                  q_cmd.len = len_byte;
               end
               CODE_SET_IDLE: begin
                  q_cmd.op  = OP_SET_IDLE;
                  q_cmd.arg = req_request_value[15:8];
               end
               CODE_SET_PROTOCOL: begin
                  q_cmd.op  = OP_SET_PROTOCOL;
                  q_cmd.arg = {7'b0000000, req_request_value[0]};
               end
               default: begin
                  q_cmd.op = OP_ACK;
               end
            endcase
         end
         default: begin
            // unused type: beat is taken and dropped
            q_push = 1'b0;
         end
      endcase
   end

endmodule

### hdl/hmks_queue.sv
// short command queue between front and back
`include "hid_macro_key_sequencer_assert.svh"
module hmks_queue
   import hmks_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `HMKS_NEVER(a_queue_no_overrun, clock, reset, push && full, "push into a full queue")
   `HMKS_NEVER(a_queue_no_underrun, clock, reset, pop && !head_valid, "pop from an empty queue")

endmodule

### hdl/hmks_back.sv
// back end: debounce, playback, control state and the result register
`include "hid_macro_key_sequencer_assert.svh"
module hmks_back
   import hmks_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  cmd_type     head_cmd,
   output logic        pop,
   input  logic [7:0]  debounce_ticks,
   input  logic        pressed_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_resp_kind,
   output logic [7:0]  rsp_report_modifier,
   output logic [7:0]  rsp_report_key,
   output logic [7:0]  rsp_data_byte,
   output logic [3:0]  rsp_data_len
);

   logic       last_sample_ff, last_sample_in;
   logic       stable_level_ff, stable_level_in;
   logic [7:0] hold_count_ff, hold_count_in;
   logic       playing_ff, playing_in;
   logic [3:0] play_index_ff, play_index_in;
   logic [7:0] last_modifier_ff, last_modifier_in;
   logic [7:0] last_key_ff, last_key_in;
   logic [7:0] idle_value_ff, idle_value_in;
   logic       report_protocol_ff, report_protocol_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] mod_ff, mod_in;
   logic [7:0] key_ff, key_in;
   logic [7:0] byte_ff, byte_in;
   logic [3:0] len_ff, len_in;

   logic                 gives_result;
   logic [7:0]           hold_next;
   logic [SEQ_CNT_W-1:0] row_next;

   assign gives_result = (head_cmd.op != OP_TICK);
   assign pop = head_valid && (!gives_result || !rsp_valid_ff || rsp_ready);
   assign row_next = {1'b0, play_index_ff} + 1'b1;

   always_comb begin
      if (head_cmd.level != last_sample_ff) begin
         hold_next = 8'd0;
      end else if (hold_count_ff < debounce_ticks) begin
         hold_next = hold_count_ff + 8'd1;
      end else begin
         hold_next = hold_count_ff;
      end
   end

   always_comb begin
      last_sample_in     = last_sample_ff;
      stable_level_in    = stable_level_ff;
      hold_count_in      = hold_count_ff;
      playing_in         = playing_ff;
      play_index_in      = play_index_ff;
      last_modifier_in   = last_modifier_ff;
      last_key_in        = last_key_ff;
      idle_value_in      = idle_value_ff;
      report_protocol_in = report_protocol_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_ready;
      kind_in            = kind_ff;
      mod_in             = mod_ff;
      key_in             = key_ff;
      byte_in            = byte_ff;
      len_in             = len_ff;
      if (pop) begin
         if (gives_result) begin
            rsp_valid_in = 1'b1;
            kind_in      = RESP_CONTROL;
            mod_in       = 8'h00;
            key_in       = 8'h00;
            byte_in      = 8'h00;
            len_in       = 4'd0;
         end
         case (head_cmd.op)
            OP_TICK: begin
               last_sample_in = head_cmd.level;
               hold_count_in  = hold_next;
               if (hold_next >= debounce_ticks && head_cmd.level != stable_level_ff) begin
                  stable_level_in = head_cmd.level;
                  // a press during playback does not restart it
                  if (head_cmd.level == pressed_level && !playing_ff) begin
                     play_index_in = 4'd0;
                     playing_in    = 1'b1;
                  end
               end
            end
            OP_POLL_KBD: begin
               kind_in = RESP_REPORT;
               len_in  = BOOT_REPORT_LEN;
               mod_in  = last_modifier_ff;
               key_in  = last_key_ff;
               if (playing_ff) begin
                  last_modifier_in = seq_modifier(play_index_ff);
                  last_key_in      = seq_key(play_index_ff);
                  mod_in           = seq_modifier(play_index_ff);
                  key_in           = seq_key(play_index_ff);
                  if (row_next >= SEQ_CNT_W'(SEQ_LEN)) begin
                     play_index_in = 4'd0;
                     playing_in    = 1'b0;
                  end else begin
                     play_index_in = row_next[3:0];
                  end
               end
            end
            OP_POLL_OTHER: begin
               kind_in = RESP_EMPTY;
            end
            OP_GET_REPORT: begin
               mod_in = last_modifier_ff;
               key_in = last_key_ff;
               len_in = head_cmd.len;
            end
            OP_GET_IDLE: begin
               byte_in = idle_value_ff;
               len_in  = head_cmd.len;
            end
            OP_GET_PROTOCOL: begin
               byte_in = {7'b0000000, report_protocol_ff};
               len_in  = head_cmd.len;
            end
            OP_SET_IDLE: begin
               idle_value_in = head_cmd.arg;
            end
            OP_SET_PROTOCOL: begin
               report_protocol_in = head_cmd.arg[0];
            end
            default: begin
               kind_in = RESP_CONTROL;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sample_ff     <= 1'b1;
         stable_level_ff    <= 1'b1;
         hold_count_ff      <= 8'd0;
         playing_ff         <= 1'b0;
         play_index_ff      <= 4'd0;
         last_modifier_ff   <= 8'h00;
         last_key_ff        <= 8'h00;
         idle_value_ff      <= 8'h00;
         report_protocol_ff <= 1'b1;
         rsp_valid_ff       <= 1'b0;
      end else begin
         last_sample_ff     <= last_sample_in;
         stable_level_ff    <= stable_level_in;
         hold_count_ff      <= hold_count_in;
         playing_ff         <= playing_in;
         play_index_ff      <= play_index_in;
         last_modifier_ff   <= last_modifier_in;
         last_key_ff        <= last_key_in;
         idle_value_ff      <= idle_value_in;
         report_protocol_ff <= report_protocol_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      mod_ff  <= mod_in;
      key_ff  <= key_in;
      byte_ff <= byte_in;
      len_ff  <= len_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_resp_kind       = kind_ff;
   assign rsp_report_modifier = mod_ff;
   assign rsp_report_key      = key_ff;
   assign rsp_data_byte       = byte_ff;
   assign rsp_data_len        = len_ff;

   `HMKS_ASSERT(a_idle_index_zero, clock, reset, !playing_ff |-> play_index_ff == 4'd0, "index moved while not playing")
   `HMKS_NEVER(a_result_not_dropped, clock, reset, pop && gives_result && rsp_valid_ff && !rsp_ready, "result register overwritten")

endmodule

### hdl/hid_macro_key_sequencer.sv
// top level of the keyboard macro sequencer: config registers and the front, queue and back
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | type, key level, endpoint, request fields
//  rsp     | out       | rsp_valid/rsp_ready  | kind, modifier, key, data byte, length
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// one beat per cycle in steady state while rsp is not held; the back end retires one
// command a cycle unless a result waits on rsp; the request beat is first written into
// the queue, and rsp_valid is registered in the back end when the command is popped;
// ticks and dropped types give no beat on rsp; while a result waits on rsp the next
// result command holds at the queue head; with two beats queued behind the result
// register req_ready drops; reset is synchronous; csr writes are always taken
`include "hid_macro_key_sequencer_assert.svh"
module hid_macro_key_sequencer
   import hmks_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic        req_key_level,
   input  logic [3:0]  req_endpoint,
   input  logic [15:0] req_request_code,
   input  logic [15:0] req_request_value,
   input  logic [15:0] req_request_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_resp_kind,
   output logic [7:0]  rsp_report_modifier,
   output logic [7:0]  rsp_report_key,
   output logic [7:0]  rsp_data_byte,
   output logic [3:0]  rsp_data_len,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic [7:0] debounce_ff;
   logic [3:0] endpoint_ff;
   logic       pressed_ff;

   logic    q_push;
   cmd_type q_cmd;
   logic    q_full;
   logic    q_pop;
   logic    head_valid;
   cmd_type head_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         endpoint_ff <= ENDPOINT_RESET;
         pressed_ff  <= PRESSED_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE: debounce_ff <= csr_data;
            CSR_ENDPOINT: endpoint_ff <= csr_data[3:0];
            CSR_PRESSED:  pressed_ff  <= csr_data[0];
            default: begin
               // write beyond the register list is ignored
            end
         endcase
      end
   end

   hmks_front u_front (
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_key_level      (req_key_level),
      .req_endpoint       (req_endpoint),
      .req_request_code   (req_request_code),
      .req_request_value  (req_request_value),
      .req_request_length (req_request_length),
      .kbd_endpoint       (endpoint_ff),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_cmd              (q_cmd)
   );

   hmks_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   hmks_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_cmd            (head_cmd),
      .pop                 (q_pop),
      .debounce_ticks      (debounce_ff),
      .pressed_level       (pressed_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_resp_kind       (rsp_resp_kind),
      .rsp_report_modifier (rsp_report_modifier),
      .rsp_report_key      (rsp_report_key),
      .rsp_data_byte       (rsp_data_byte),
      .rsp_data_len        (rsp_data_len)
   );

   `HMKS_ASSERT(a_empty_packet_blank, clock, reset, rsp_valid && rsp_resp_kind == RESP_EMPTY |-> rsp_data_len == 4'd0 && rsp_report_key == 8'h00, "empty packet carries data")
   `HMKS_ASSERT(a_len_in_range, clock, reset, rsp_valid |-> rsp_data_len <= BOOT_REPORT_LEN, "reply length beyond a boot report")

endmodule
